// ===== rtl/kdq_pkg.sv =====
`timescale 1ns / 1ps

package kdq_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int CODE_BITS    = 16;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int FILL_W       = $clog2(MAX_ELEMENTS + 1);

    localparam int VALUE_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int BOUND_W  = 34;
    localparam int DELTA_W  = 35;
    localparam int ALU_W    = 36;
    localparam int RANGE_W  = 31;
    localparam int SCALE_W  = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};
    localparam logic [DIFF_W-1:0]    DIFF_MOST_POS = {1'b0, {(DIFF_W-1){1'b1}}};
    localparam logic [DIFF_W-1:0]    DIFF_MOST_NEG = {1'b1, {(DIFF_W-1){1'b0}}};

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(65536);
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'hFFFF_0000;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RANGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SCALE   = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MIN,
        ST_MAX,
        ST_CENTRE,
        ST_LOW,
        ST_HIGH,
        ST_SPREAD,
        ST_EXCEED,
        ST_READ,
        ST_SUB,
        ST_MUL,
        ST_SAT,
        ST_OUT
    } kdq_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_MIN,
        OP_MAX,
        OP_CENTRE,
        OP_LOW,
        OP_HIGH,
        OP_SPREAD,
        OP_EXCEED,
        OP_SUB,
        OP_MUL,
        OP_SAT
    } kdq_op_t;

    typedef struct packed {
        kdq_op_t op;
        logic    capture;
        logic    clear_run;
    } kdq_ctrl_t;

endpackage

// ===== rtl/kdq_ram.sv =====
`timescale 1ns / 1ps

module kdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/kdq_datapath.sv =====
`timescale 1ns / 1ps

module kdq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  kdq_pkg::kdq_ctrl_t                ctrl,
    input  logic                              cfg_we,
    input  logic [kdq_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [kdq_pkg::SCALE_W-1:0]       cfg_wdata,
    input  logic [kdq_pkg::VALUE_W-1:0]       frame_value,
    input  logic [kdq_pkg::VALUE_W-1:0]       key_value,
    input  logic [kdq_pkg::DIFF_W-1:0]        store_rdata,
    output logic [kdq_pkg::DIFF_W-1:0]        store_wdata,
    output logic [kdq_pkg::CODE_BITS-1:0]     code,
    output logic [kdq_pkg::BOUND_W-1:0]       window_low,
    output logic [kdq_pkg::BOUND_W-1:0]       window_high,
    output logic                              range_exceeded
);

    localparam int AW = kdq_pkg::ALU_W;

    logic [kdq_pkg::RANGE_W-1:0]   window_range_reg;
    logic [kdq_pkg::SCALE_W-1:0]   code_scale_reg;
    logic [kdq_pkg::VALUE_W-1:0]   frame_reg;
    logic [kdq_pkg::VALUE_W-1:0]   key_reg;
    logic [kdq_pkg::DIFF_W-1:0]    diff_reg;
    logic [kdq_pkg::DIFF_W-1:0]    min_reg;
    logic [kdq_pkg::DIFF_W-1:0]    max_reg;
    logic [AW-1:0]                 acc_reg;
    logic [kdq_pkg::BOUND_W-1:0]   low_reg;
    logic [kdq_pkg::BOUND_W-1:0]   high_reg;
    logic                          exceed_reg;
    logic [kdq_pkg::DELTA_W-1:0]   delta_reg;
    logic                          positive_reg;
    logic [63:0]                   prod_lo_reg;
    logic [kdq_pkg::BOUND_W-1:0]   prod_hi_reg;
    logic [kdq_pkg::CODE_BITS-1:0] code_reg;

    logic [AW-1:0] a_op;
    logic [AW-1:0] b_op;
    logic          sub;
    logic [AW-1:0] sum;
    logic [AW-1:0] scaled;
    logic [kdq_pkg::CODE_BITS-1:0] code_next;

    // One shared adder does the adds, subtracts and compares up to OP_SUB.
    always_comb begin
        a_op = '0;
        b_op = '0;
        sub  = 1'b0;
        unique case (ctrl.op)
            kdq_pkg::OP_DIFF: begin
                a_op = {{(AW-kdq_pkg::VALUE_W){frame_reg[kdq_pkg::VALUE_W-1]}}, frame_reg};
                b_op = {{(AW-kdq_pkg::VALUE_W){key_reg[kdq_pkg::VALUE_W-1]}}, key_reg};
                sub  = 1'b1;
            end
            kdq_pkg::OP_MIN: begin
                a_op = {{(AW-kdq_pkg::DIFF_W){diff_reg[kdq_pkg::DIFF_W-1]}}, diff_reg};
                b_op = {{(AW-kdq_pkg::DIFF_W){min_reg[kdq_pkg::DIFF_W-1]}}, min_reg};
                sub  = 1'b1;
            end
            kdq_pkg::OP_MAX: begin
                a_op = {{(AW-kdq_pkg::DIFF_W){max_reg[kdq_pkg::DIFF_W-1]}}, max_reg};
                b_op = {{(AW-kdq_pkg::DIFF_W){diff_reg[kdq_pkg::DIFF_W-1]}}, diff_reg};
                sub  = 1'b1;
            end
            kdq_pkg::OP_CENTRE: begin
                a_op = {{(AW-kdq_pkg::DIFF_W){min_reg[kdq_pkg::DIFF_W-1]}}, min_reg};
                b_op = {{(AW-kdq_pkg::DIFF_W){max_reg[kdq_pkg::DIFF_W-1]}}, max_reg};
            end
            kdq_pkg::OP_LOW: begin
                a_op = {acc_reg[AW-1], acc_reg[AW-1:1]};
                b_op = AW'(window_range_reg[kdq_pkg::RANGE_W-1:1]);
                sub  = 1'b1;
            end
            kdq_pkg::OP_HIGH: begin
                a_op = {{(AW-kdq_pkg::BOUND_W){low_reg[kdq_pkg::BOUND_W-1]}}, low_reg};
                b_op = AW'(window_range_reg);
            end
            kdq_pkg::OP_SPREAD: begin
                a_op = {{(AW-kdq_pkg::DIFF_W){max_reg[kdq_pkg::DIFF_W-1]}}, max_reg};
                b_op = {{(AW-kdq_pkg::DIFF_W){min_reg[kdq_pkg::DIFF_W-1]}}, min_reg};
                sub  = 1'b1;
            end
            kdq_pkg::OP_EXCEED: begin
                a_op = AW'(window_range_reg);
                b_op = acc_reg;
                sub  = 1'b1;
            end
            kdq_pkg::OP_SUB: begin
                a_op = {{(AW-kdq_pkg::DIFF_W){store_rdata[kdq_pkg::DIFF_W-1]}}, store_rdata};
                b_op = {{(AW-kdq_pkg::BOUND_W){low_reg[kdq_pkg::BOUND_W-1]}}, low_reg};
                sub  = 1'b1;
            end
            default: begin
                a_op = '0;
                b_op = '0;
                sub  = 1'b0;
            end
        endcase
    end

    assign sum = a_op + (sub ? ~b_op : b_op) + AW'(sub);

    assign scaled = AW'(prod_hi_reg) + AW'(prod_lo_reg[63:32]);

    always_comb begin
        if (!positive_reg) begin
            code_next = '0;
        end else if (scaled > AW'(kdq_pkg::CODE_MAX)) begin
            code_next = kdq_pkg::CODE_MAX;
        end else begin
            code_next = scaled[kdq_pkg::CODE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_range_reg <= kdq_pkg::RANGE_RESET;
            code_scale_reg   <= kdq_pkg::SCALE_RESET;
        end else if (cfg_we) begin
            if (cfg_idx == kdq_pkg::REG_WINDOW_RANGE) begin
                window_range_reg <= cfg_wdata[kdq_pkg::RANGE_W-1:0];
            end
            if (cfg_idx == kdq_pkg::REG_CODE_SCALE) begin
                code_scale_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear_run) begin
            min_reg <= kdq_pkg::DIFF_MOST_POS;
            max_reg <= kdq_pkg::DIFF_MOST_NEG;
        end else begin
            if (ctrl.op == kdq_pkg::OP_MIN && sum[AW-1]) begin
                min_reg <= diff_reg;
            end
            if (ctrl.op == kdq_pkg::OP_MAX && sum[AW-1]) begin
                max_reg <= diff_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            frame_reg <= frame_value;
            key_reg   <= key_value;
        end
        unique case (ctrl.op)
            kdq_pkg::OP_DIFF:   diff_reg   <= sum[kdq_pkg::DIFF_W-1:0];
            kdq_pkg::OP_CENTRE: acc_reg    <= sum;
            kdq_pkg::OP_LOW:    low_reg    <= sum[kdq_pkg::BOUND_W-1:0];
            kdq_pkg::OP_HIGH:   high_reg   <= sum[kdq_pkg::BOUND_W-1:0];
            kdq_pkg::OP_SPREAD: acc_reg    <= sum;
            kdq_pkg::OP_EXCEED: exceed_reg <= sum[AW-1];
            kdq_pkg::OP_SUB:    delta_reg  <= sum[kdq_pkg::DELTA_W-1:0];
            kdq_pkg::OP_MUL: begin
                positive_reg <= !delta_reg[kdq_pkg::DELTA_W-1] && (delta_reg != '0);
                prod_lo_reg  <= 64'(delta_reg[31:0]) * 64'(code_scale_reg);
                prod_hi_reg  <= kdq_pkg::BOUND_W'(delta_reg[33:32])
                                * kdq_pkg::BOUND_W'(code_scale_reg);
            end
            kdq_pkg::OP_SAT:    code_reg   <= code_next;
            default: begin
            end
        endcase
    end

    assign store_wdata    = sum[kdq_pkg::DIFF_W-1:0];
    assign code           = code_reg;
    assign window_low     = low_reg;
    assign window_high    = high_reg;
    assign range_exceeded = exceed_reg;

endmodule

// ===== rtl/kdq_seq.sv =====
`timescale 1ns / 1ps

module kdq_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic                           in_last,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_last,
    output kdq_pkg::kdq_ctrl_t             ctrl,
    output logic                           store_we,
    output logic [kdq_pkg::ADDR_W-1:0]     store_waddr,
    output logic [kdq_pkg::ADDR_W-1:0]     store_raddr
);

    kdq_pkg::kdq_state_t state_reg;
    kdq_pkg::kdq_state_t state_next;

    logic [kdq_pkg::FILL_W-1:0] fill_reg;
    logic [kdq_pkg::ADDR_W-1:0] idx_reg;
    logic                       last_reg;
    logic                       final_reg;
    logic                       close_run;
    logic                       at_final;

    assign close_run = last_reg || (fill_reg == kdq_pkg::FILL_W'(kdq_pkg::MAX_ELEMENTS));
    assign at_final  = (kdq_pkg::FILL_W'(idx_reg) + kdq_pkg::FILL_W'(1)) == fill_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kdq_pkg::ST_IDLE:   if (in_valid) state_next = kdq_pkg::ST_DIFF;
            kdq_pkg::ST_DIFF:   state_next = kdq_pkg::ST_MIN;
            kdq_pkg::ST_MIN:    state_next = kdq_pkg::ST_MAX;
            kdq_pkg::ST_MAX:    state_next = close_run ? kdq_pkg::ST_CENTRE : kdq_pkg::ST_IDLE;
            kdq_pkg::ST_CENTRE: state_next = kdq_pkg::ST_LOW;
            kdq_pkg::ST_LOW:    state_next = kdq_pkg::ST_HIGH;
            kdq_pkg::ST_HIGH:   state_next = kdq_pkg::ST_SPREAD;
            kdq_pkg::ST_SPREAD: state_next = kdq_pkg::ST_EXCEED;
            kdq_pkg::ST_EXCEED: state_next = kdq_pkg::ST_READ;
            kdq_pkg::ST_READ:   state_next = kdq_pkg::ST_SUB;
            kdq_pkg::ST_SUB:    state_next = kdq_pkg::ST_MUL;
            kdq_pkg::ST_MUL:    state_next = kdq_pkg::ST_SAT;
            kdq_pkg::ST_SAT:    state_next = kdq_pkg::ST_OUT;
            kdq_pkg::ST_OUT: begin
                if (out_ready) begin
                    state_next = final_reg ? kdq_pkg::ST_IDLE : kdq_pkg::ST_READ;
                end
            end
            default:            state_next = kdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.op        = kdq_pkg::OP_NONE;
        ctrl.capture   = 1'b0;
        ctrl.clear_run = 1'b0;
        unique case (state_reg)
            kdq_pkg::ST_IDLE:   ctrl.capture = in_valid;
            kdq_pkg::ST_DIFF:   ctrl.op = kdq_pkg::OP_DIFF;
            kdq_pkg::ST_MIN:    ctrl.op = kdq_pkg::OP_MIN;
            kdq_pkg::ST_MAX:    ctrl.op = kdq_pkg::OP_MAX;
            kdq_pkg::ST_CENTRE: ctrl.op = kdq_pkg::OP_CENTRE;
            kdq_pkg::ST_LOW:    ctrl.op = kdq_pkg::OP_LOW;
            kdq_pkg::ST_HIGH:   ctrl.op = kdq_pkg::OP_HIGH;
            kdq_pkg::ST_SPREAD: ctrl.op = kdq_pkg::OP_SPREAD;
            kdq_pkg::ST_EXCEED: ctrl.op = kdq_pkg::OP_EXCEED;
            kdq_pkg::ST_SUB:    ctrl.op = kdq_pkg::OP_SUB;
            kdq_pkg::ST_MUL:    ctrl.op = kdq_pkg::OP_MUL;
            kdq_pkg::ST_SAT:    ctrl.op = kdq_pkg::OP_SAT;
            kdq_pkg::ST_OUT:    ctrl.clear_run = out_ready && final_reg;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kdq_pkg::ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == kdq_pkg::ST_IDLE && in_valid) begin
                last_reg <= in_last;
            end
            if (state_reg == kdq_pkg::ST_DIFF) begin
                fill_reg <= fill_reg + kdq_pkg::FILL_W'(1);
            end
            if (state_reg == kdq_pkg::ST_EXCEED) begin
                idx_reg <= '0;
            end
            if (state_reg == kdq_pkg::ST_SAT) begin
                final_reg <= at_final;
            end
            if (state_reg == kdq_pkg::ST_OUT && out_ready) begin
                if (final_reg) begin
                    fill_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + kdq_pkg::ADDR_W'(1);
                end
            end
        end
    end

    assign in_ready    = (state_reg == kdq_pkg::ST_IDLE);
    assign out_valid   = (state_reg == kdq_pkg::ST_OUT);
    assign out_last    = final_reg;
    assign store_we    = (state_reg == kdq_pkg::ST_DIFF);
    assign store_waddr = fill_reg[kdq_pkg::ADDR_W-1:0];
    assign store_raddr = idx_reg;

endmodule

// ===== rtl/keyframe_delta_quantizer_top.sv =====
`timescale 1ns / 1ps

// Keyframe delta quantizer. Each input transfer carries a frame coordinate and its keyframe
// coordinate; the block stores their difference and keeps the running minimum and maximum.
// A run closes on tlast or when 64 differences are held, and the block then emits one 16-bit
// code per stored difference, in order, with the window bounds, the spread-exceeded flag in
// m_tuser and tlast on the final code. A small sequencer runs the adds, subtracts and compares,
// apart from the product sum and saturation test, through one shared 36-bit adder. An input
// transfer passes an accepting state and three adder steps, closing a run adds five adder steps,
// and each code passes store read, subtract, multiply, saturate and an m_tready-held transfer.
// Configuration writes are accepted every cycle and must only be made while the block is idle.
module keyframe_delta_quantizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // frame_value [31:0], key_value [63:32]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // code [15:0], window_low [49:16], window_high [83:50], zero
    output logic [0:0]  m_tuser,   // range_exceeded [0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [kdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    kdq_pkg::kdq_ctrl_t ctrl;

    logic                            store_we;
    logic [kdq_pkg::ADDR_W-1:0]      store_waddr;
    logic [kdq_pkg::ADDR_W-1:0]      store_raddr;
    logic [kdq_pkg::DIFF_W-1:0]      store_wdata;
    logic [kdq_pkg::DIFF_W-1:0]      store_rdata;
    logic [kdq_pkg::CODE_BITS-1:0]   code;
    logic [kdq_pkg::BOUND_W-1:0]     window_low;
    logic [kdq_pkg::BOUND_W-1:0]     window_high;
    logic                            range_exceeded;

    assign cfg_ready = 1'b1;

    kdq_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_last     (s_tlast),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_last    (m_tlast),
        .ctrl        (ctrl),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_raddr (store_raddr)
    );

    kdq_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_idx        (cfg_index),
        .cfg_wdata      (cfg_data),
        .frame_value    (s_tdata[31:0]),
        .key_value      (s_tdata[63:32]),
        .store_rdata    (store_rdata),
        .store_wdata    (store_wdata),
        .code           (code),
        .window_low     (window_low),
        .window_high    (window_high),
        .range_exceeded (range_exceeded)
    );

    kdq_ram #(
        .WIDTH (kdq_pkg::DIFF_W),
        .DEPTH (kdq_pkg::MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    assign m_tdata = {4'b0000, window_high, window_low, code};
    assign m_tuser = range_exceeded;

`ifndef SYNTHESIS
    a_one_side_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels active together");

    a_run_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("block not idle after the final code of a run");

    a_code_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid && !s_tready)
        else $error("next code presented without a computation step");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PAIRS = 16;
    localparam int DIRECTED_ROWS = 13;

    typedef struct {
        logic [15:0] code;
        logic [33:0] low_bound;
        logic [33:0] high_bound;
        logic        exceeded;
        logic        closing;
    } code_rec_t;

    typedef struct {
        logic [31:0] frame;
        logic [31:0] key;
        logic        lst;
        logic        typed;
        logic [15:0] code;
        logic        exceeded;
    } pair_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [87:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [kdq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int code_errors = 0;
    int cycle_count = 0;

    logic [kdq_pkg::RANGE_W-1:0] range_reg;
    logic [kdq_pkg::SCALE_W-1:0] scale_reg;
    longint             run_store [kdq_pkg::MAX_ELEMENTS];
    longint             run_min;
    longint             run_max;
    int                 run_fill;

    code_rec_t pending_codes [$];

    // Typed codes hold for the reset window of width 1.0 and scale 65535.
    pair_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 16'd0,     1'b0},
        '{32'h0001_0000, 32'h0000_0000, 1'b1, 1'b1, 16'd65535, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 16'd0,     1'b1},
        '{32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1, 16'd65535, 1'b1},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 16'd0,     1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0,     1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 16'd0,     1'b0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 16'd0,     1'b0},
        '{32'h0000_8000, 32'h0001_0000, 1'b1, 1'b0, 16'd0,     1'b0}
    };

    keyframe_delta_quantizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void clear_run();
        run_min = 64'sd4294967295;
        run_max = -64'sd4294967296;
        run_fill = 0;
    endfunction

    function automatic int quantize_pair(input logic [31:0] frame, input logic [31:0] key,
                                         input logic lst, output code_rec_t recs [64]);
        longint            d;
        longint            centre;
        longint            low;
        longint            high;
        longint            t;
        longint unsigned   ut;
        longint unsigned   prod;
        longint unsigned   scale64;
        logic              exc;
        int                n;
        d = longint'($signed(frame)) - longint'($signed(key));
        run_store[run_fill] = d;
        run_fill++;
        if (d < run_min) run_min = d;
        if (d > run_max) run_max = d;
        if (!lst && run_fill < kdq_pkg::MAX_ELEMENTS) return 0;
        n = run_fill;
        centre = (run_min + run_max) >>> 1;
        low = centre - longint'(range_reg >> 1);
        high = low + longint'(range_reg);
        exc = (run_max - run_min) > longint'(range_reg);
        scale64 = longint'(scale_reg);
        for (int i = 0; i < n; i++) begin
            t = run_store[i] - low;
            if (t <= 0) begin
                recs[i].code = '0;
            end else begin
                ut = t;
                prod = (ut >> 32) * scale64 + (((ut & 64'hFFFF_FFFF) * scale64) >> 32);
                recs[i].code = (prod > 64'(kdq_pkg::CODE_MAX)) ? kdq_pkg::CODE_MAX
                                                               : prod[15:0];
            end
            recs[i].low_bound = low[33:0];
            recs[i].high_bound = high[33:0];
            recs[i].exceeded = exc;
            recs[i].closing = (i == n - 1);
        end
        clear_run();
        return n;
    endfunction

    function automatic void post_codes(input code_rec_t recs [64], input int n);
        for (int i = 0; i < n; i++) pending_codes.push_back(recs[i]);
    endfunction

    function automatic logic [31:0] scale_for(input logic [30:0] rng);
        longint unsigned q;
        if (rng == 0) return '1;
        q = (64'd65535 << 32) / rng;
        return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    task automatic write_reg(input logic [kdq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == kdq_pkg::REG_WINDOW_RANGE) range_reg = value[30:0];
        else if (idx == kdq_pkg::REG_CODE_SCALE) scale_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(input logic [31:0] frame, input logic [31:0] key, input logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {key, frame};
        s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic settle(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        code_rec_t want;
        code_rec_t got;
        got.code = m_tdata[15:0];
        got.low_bound = m_tdata[49:16];
        got.high_bound = m_tdata[83:50];
        got.exceeded = m_tuser[0];
        got.closing = m_tlast;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                code_errors++;
                if (code_errors <= 10)
                    $display("Unexpected code transfer: code %0d low %h high %h", got.code,
                             got.low_bound, got.high_bound);
            end else begin
                want = pending_codes.pop_front();
                if (got.code !== want.code || got.low_bound !== want.low_bound ||
                    got.high_bound !== want.high_bound || got.exceeded !== want.exceeded ||
                    got.closing !== want.closing) begin
                    code_errors++;
                    if (code_errors <= 10)
                        $display("Code mismatch: expected %0d/%h/%h/%b/%b, got %0d/%h/%h/%b/%b",
                                 want.code, want.low_bound, want.high_bound, want.exceeded,
                                 want.closing, got.code, got.low_bound, got.high_bound,
                                 got.exceeded, got.closing);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        code_rec_t       recs [64];
        int              n;
        int              row;
        int              done;
        int              len;
        logic            full_last;
        logic            lst;
        logic [30:0]     rng;
        logic [31:0]     scl;
        logic [31:0]     fv;
        logic [31:0]     kv;
        longint          sp;
        longint          centre_val;
        longint unsigned off;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        range_reg = kdq_pkg::RANGE_RESET;
        scale_reg = kdq_pkg::SCALE_RESET;
        clear_run();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_pair(directed_rows[i].frame, directed_rows[i].key, directed_rows[i].lst);
            n = quantize_pair(directed_rows[i].frame, directed_rows[i].key,
                              directed_rows[i].lst, recs);
            for (int k = 0; k < n; k++) begin
                row = i - n + 1 + k;
                if (directed_rows[row].typed) begin
                    recs[k].code = directed_rows[row].code;
                    recs[k].exceeded = directed_rows[row].exceeded;
                end
            end
            post_codes(recs, n);
        end

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            settle(12);
            case (phase)
                1: begin rng = 31'd131072; scl = scale_for(rng); end
                2: begin rng = 31'h7FFF_FFFF; scl = scale_for(rng); end
                3: begin rng = 31'd1; scl = 32'hFFFF_FFFF; end
                4: begin rng = '0; scl = '0; end
                5: begin rng = $urandom_range(1, 1 << 20); scl = scale_for(rng); end
                6: begin rng = $urandom_range(1, 32'h7FFF_FFFF); scl = scale_for(rng); end
                7: begin rng = $urandom_range(1, 1 << 24); scl = $urandom; end
                default: begin rng = kdq_pkg::RANGE_RESET; scl = kdq_pkg::SCALE_RESET; end
            endcase
            write_reg(kdq_pkg::REG_WINDOW_RANGE, {1'b0, rng});
            write_reg(kdq_pkg::REG_CODE_SCALE, scl);
            case (phase % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 68; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 68; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase

            done = 0;
            while (done < PHASE_PAIRS) begin
                if (done == 0 && phase <= 2) len = kdq_pkg::MAX_ELEMENTS;
                else if ($urandom_range(24) == 0) len = kdq_pkg::MAX_ELEMENTS;
                else len = $urandom_range(1, 8);
                // A full store closes the run whether or not tlast is set.
                full_last = (phase == 2) || (phase != 1 && $urandom_range(1));
                case ($urandom_range(2))
                    0: sp = longint'(range_reg) / 4;
                    1: sp = longint'(range_reg);
                    default: sp = longint'(range_reg) * 3;
                endcase
                centre_val = longint'($signed($urandom)) >>> 1;
                for (int j = 0; j < len; j++) begin
                    lst = (j == len - 1) && (len != kdq_pkg::MAX_ELEMENTS || full_last);
                    kv = $urandom;
                    if ($urandom_range(5) == 0) begin
                        fv = $urandom;
                    end else begin
                        off = {$urandom, $urandom} % (sp + 1);
                        fv = kv + 32'(centre_val + longint'(off) - sp / 2);
                    end
                    send_pair(fv, kv, lst);
                    n = quantize_pair(fv, kv, lst, recs);
                    post_codes(recs, n);
                    done++;
                end
            end
        end

        settle(50);
        if (code_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
